[rtl/cc20_pkg.sv]
// Shared types, constants and round functions of the ChaCha20 stream XOR block.
// No dependencies; every other file of the block imports this package.
package cc20_pkg;

    // Cipher constants ("expand 32-byte k") and round count.
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEP_W = $clog2(DOUBLE_ROUNDS + 1);

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int DATA_W = 64;
    localparam int COUNT_W = 4;
    localparam int POS_W = 3;
    localparam int TDATA_W = 72;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 4'd8;

    typedef logic [15:0][31:0] cc20_block_t;
    typedef logic [3:0][31:0] cc20_quad_t;

    // Key and nonce words in state order.
    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } cc20_cfg_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic [POS_W-1:0]   pos;
        logic               new_block;
        logic [31:0]        ctr;
    } cc20_entry_t;

    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] pos;
    } cc20_front_stat_t;

    typedef struct packed {
        logic core_busy;
        logic spare_valid;
    } cc20_back_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // One quarter round on words a, b, c, d (index 0..3 of the quad).
    function automatic cc20_quad_t mix_quad(input cc20_quad_t q);
        logic [31:0] a, b, c, d;
        a = q[0]; b = q[1]; c = q[2]; d = q[3];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        mix_quad = {d, c, b, a};
    endfunction

    // Column round followed by diagonal round.
    function automatic cc20_block_t double_round(input cc20_block_t w);
        cc20_block_t t;
        cc20_quad_t q;
        t = w;
        for (int i = 0; i < 4; i++) begin
            q = mix_quad({t[12+i], t[8+i], t[4+i], t[i]});
            t[i] = q[0]; t[4+i] = q[1]; t[8+i] = q[2]; t[12+i] = q[3];
        end
        for (int i = 0; i < 4; i++) begin
            q = mix_quad({t[12+((i+3)&3)], t[8+((i+2)&3)], t[4+((i+1)&3)], t[i]});
            t[i] = q[0];
            t[4+((i+1)&3)] = q[1];
            t[8+((i+2)&3)] = q[2];
            t[12+((i+3)&3)] = q[3];
        end
        double_round = t;
    endfunction

    // Initial state of one block.
    function automatic cc20_block_t init_block(input cc20_cfg_t cfg, input logic [31:0] ctr);
        cc20_block_t w;
        w[0] = SIGMA_0; w[1] = SIGMA_1; w[2] = SIGMA_2; w[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            w[4+i] = cfg.key[i];
        end
        w[12] = ctr;
        w[13] = cfg.nonce[0];
        w[14] = cfg.nonce[1];
        w[15] = cfg.nonce[2];
        init_block = w;
    endfunction

endpackage

[rtl/chacha20_stream_xor.sv]
// ChaCha20 stream XOR, top level: configuration registers, front, queue, back.
// Depends on cc20_pkg, cc20_front, cc20_queue and cc20_back.
//
// Usage: program key, nonce and initial counter through the write port while
// no message is in flight. Each input transfer carries up to eight message
// bytes (first byte in the low bits) and a byte count; tlast ends a message,
// and the next transfer starts a new one at the initial counter.
// Each input transfer produces exactly one output transfer, in order, with the
// bytes XORed with keystream and the bytes past the count set to zero.
// When the keystream block is ready, an input transfer is registered in the
// queue and then in the output register. A new 64-byte block is made in the
// block generator (load, ten double rounds, final add) before output valid for
// the first item of a message. The next block is prefetched while the current
// one is used; the prefetch is launched from a registered request once the
// current block is taken, so the rate of a running message is set by the generator.
// Reset clears the configuration and control registers, the queue and any
// prefetched block. When the receiver stalls, the output register holds its
// transfer, the queue fills, and s_tready drops once the queue is full. A
// register write drops any prefetched block.
module chacha20_stream_xor #(
    parameter int QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cc20_pkg::TDATA_W-1:0]  s_tdata,   // data_in [63:0], byte_count [67:64]
    input  logic                          s_tlast,   // last_of_message
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cc20_pkg::TDATA_W-1:0]  m_tdata,   // data_out [63:0], out_count [67:64]
    output logic                          m_tlast,   // out_last
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_addr,
    input  logic [63:0]                   cfg_wdata
);
    import cc20_pkg::*;

    localparam logic [2:0] REG_KEY_0      = 3'd0;
    localparam logic [2:0] REG_KEY_1      = 3'd1;
    localparam logic [2:0] REG_KEY_2      = 3'd2;
    localparam logic [2:0] REG_KEY_3      = 3'd3;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_INIT_CTR   = 3'd6;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg, init_ctr_reg;

    cc20_cfg_t        cfg;
    cc20_entry_t      q_entry, q_head;
    logic             q_push, q_ready, q_pop, q_head_valid;
    cc20_front_stat_t front_stat;
    cc20_back_stat_t  back_stat;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_KEY_0:      key0_reg       <= cfg_wdata;
                REG_KEY_1:      key1_reg       <= cfg_wdata;
                REG_KEY_2:      key2_reg       <= cfg_wdata;
                REG_KEY_3:      key3_reg       <= cfg_wdata;
                REG_NONCE_LOW:  nonce_low_reg  <= cfg_wdata;
                REG_NONCE_HIGH: nonce_high_reg <= cfg_wdata[31:0];
                REG_INIT_CTR:   init_ctr_reg   <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Key and nonce in state word order.
    always_comb begin
        cfg.key[0]   = key0_reg[31:0];
        cfg.key[1]   = key0_reg[63:32];
        cfg.key[2]   = key1_reg[31:0];
        cfg.key[3]   = key1_reg[63:32];
        cfg.key[4]   = key2_reg[31:0];
        cfg.key[5]   = key2_reg[63:32];
        cfg.key[6]   = key3_reg[31:0];
        cfg.key[7]   = key3_reg[63:32];
        cfg.nonce[0] = nonce_low_reg[31:0];
        cfg.nonce[1] = nonce_low_reg[63:32];
        cfg.nonce[2] = nonce_high_reg;
    end

    cc20_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .msg_start_ctr (init_ctr_reg),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_entry       (q_entry),
        .stat          (front_stat)
    );

    cc20_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .ready      (q_ready),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    cc20_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .cfg        (cfg),
        .cfg_change (cfg_wr_en),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .stat       (back_stat)
    );

    // The generator never runs while a finished block still waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(back_stat.core_busy && back_stat.spare_valid))
        else $error("block generator busy while a prefetched block is held");

    // An input transfer marked last closes the message in the front.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !front_stat.active)
        else $error("message still active after its last transfer");

    // Output byte counts stay within one item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DATA_W +: COUNT_W] <= MAX_COUNT))
        else $error("output byte count above eight");

endmodule

[rtl/cc20_front.sv]
// Front part: accepts input transfers, tracks message position and block counter,
// and classifies each item before it enters the queue. Depends on cc20_pkg.
module cc20_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cc20_pkg::TDATA_W-1:0]  s_tdata,   // data_in [63:0], byte_count [67:64]
    input  logic                          s_tlast,   // last_of_message
    input  logic [31:0]                   msg_start_ctr,
    input  logic                          q_ready,
    output logic                          q_push,
    output cc20_pkg::cc20_entry_t         q_entry,
    output cc20_pkg::cc20_front_stat_t    stat
);
    import cc20_pkg::*;

    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      ctr_reg, ctr_next;

    logic [POS_W-1:0]   pos_cur;
    logic [31:0]        ctr_cur;
    logic [COUNT_W-1:0] raw_count;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // A new message starts at the configured counter and at slot zero.
    always_comb begin
        pos_cur   = active_reg ? pos_reg : '0;
        ctr_cur   = active_reg ? ctr_reg : msg_start_ctr;
        raw_count = s_tdata[DATA_W +: COUNT_W];

        q_entry.data      = s_tdata[DATA_W-1:0];
        q_entry.count     = (raw_count > MAX_COUNT) ? MAX_COUNT : raw_count;
        q_entry.last      = s_tlast;
        q_entry.pos       = pos_cur;
        q_entry.new_block = (pos_cur == '0);
        q_entry.ctr       = ctr_cur;
    end

    // Position advances per transfer, counter per new block; tlast closes the message.
    always_comb begin
        active_next = active_reg;
        pos_next    = pos_reg;
        ctr_next    = ctr_reg;
        if (q_push) begin
            if (s_tlast) begin
                active_next = 1'b0;
                pos_next    = '0;
                ctr_next    = msg_start_ctr;
            end else begin
                active_next = 1'b1;
                pos_next    = pos_cur + POS_W'(1);
                ctr_next    = q_entry.new_block ? ctr_cur + 32'd1 : ctr_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            ctr_reg    <= '0;
        end else begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            ctr_reg    <= ctr_next;
        end
    end

    assign stat.active = active_reg;
    assign stat.pos    = pos_reg;

endmodule

[rtl/cc20_queue.sv]
// Short queue of classified items between the front and the back.
// Depends on cc20_pkg for the entry type.
module cc20_queue #(
    parameter int DEPTH = cc20_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cc20_pkg::cc20_entry_t  push_entry,
    output logic                   ready,
    input  logic                   pop,
    output cc20_pkg::cc20_entry_t  head,
    output logic                   head_valid
);
    import cc20_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cc20_entry_t      entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign ready      = (cnt_reg != FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head       = entries[rd_ptr_reg];

    // Pointer and fill count update; push and pop may happen together.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/cc20_core.sv]
// Iterative block generator: one double round per cycle, then the final add.
// Depends on cc20_pkg for the round functions and block type.
module cc20_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [31:0]            start_ctr,
    input  logic                   abort,
    input  cc20_pkg::cc20_cfg_t    cfg,
    output logic                   busy,
    output logic                   done,
    output cc20_pkg::cc20_block_t  result,
    output logic [31:0]            result_ctr
);
    import cc20_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DOUBLE_ROUNDS);

    cc20_block_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [31:0]       ctr_reg, ctr_next;
    cc20_block_t       init_words;

    assign busy       = busy_reg;
    assign done       = busy_reg && (step_reg == LAST_STEP);
    assign result_ctr = ctr_reg;

    // Final add of the initial state, done in a cycle of its own.
    always_comb begin
        init_words = init_block(cfg, ctr_reg);
        for (int i = 0; i < 16; i++) begin
            result[i] = state_reg[i] + init_words[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        ctr_next   = ctr_reg;
        if (abort) begin
            busy_next = 1'b0;
        end else if (start) begin
            busy_next  = 1'b1;
            step_next  = '0;
            ctr_next   = start_ctr;
            state_next = init_block(cfg, start_ctr);
        end else if (busy_reg) begin
            if (done) begin
                busy_next = 1'b0;
            end else begin
                state_next = double_round(state_reg);
                step_next  = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        ctr_reg   <= ctr_next;
    end

endmodule

[rtl/cc20_back.sv]
// Back part: holds the current and the prefetched keystream block, XORs items
// and drives the output register. Depends on cc20_pkg and cc20_core.
module cc20_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cc20_pkg::cc20_entry_t         head,
    input  logic                          head_valid,
    output logic                          pop,
    input  cc20_pkg::cc20_cfg_t           cfg,
    input  logic                          cfg_change,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cc20_pkg::TDATA_W-1:0]  m_tdata,   // data_out [63:0], out_count [67:64]
    output logic                          m_tlast,   // out_last
    output cc20_pkg::cc20_back_stat_t     stat
);
    import cc20_pkg::*;

    cc20_block_t cur_reg, cur_next;
    cc20_block_t spare_reg, spare_next;
    logic [31:0] spare_tag_reg, spare_tag_next;
    logic        spare_valid_reg, spare_valid_next;
    logic        pf_pending_reg, pf_pending_next;
    logic [31:0] pf_ctr_reg, pf_ctr_next;
    logic        m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_data_reg, m_data_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic        m_last_reg, m_last_next;

    logic        demand, hit, stale, out_free;
    logic        core_start, core_busy, core_done;
    logic [31:0] core_start_ctr, core_ctr;
    cc20_block_t core_result;
    cc20_block_t ks_src;
    logic [3:0]  word_idx;
    logic [DATA_W-1:0] ks, mask;

    cc20_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .start_ctr  (core_start_ctr),
        .abort      (cfg_change),
        .cfg        (cfg),
        .busy       (core_busy),
        .done       (core_done),
        .result     (core_result),
        .result_ctr (core_ctr)
    );

    // Classification of the head item against the prefetched block.
    assign demand   = head_valid && head.new_block;
    assign hit      = demand && spare_valid_reg && (spare_tag_reg == head.ctr);
    assign stale    = demand && spare_valid_reg && (spare_tag_reg != head.ctr);
    assign out_free = !m_valid_reg || m_tready;
    assign pop      = head_valid && out_free && (!head.new_block || hit);

    // The generator runs on demand for the head item, otherwise on the prefetch.
    assign core_start     = !core_busy && !spare_valid_reg && !cfg_change
                            && (demand || pf_pending_reg);
    assign core_start_ctr = demand ? head.ctr : pf_ctr_reg;

    // Keystream word pair and byte mask for the head item.
    always_comb begin
        ks_src   = head.new_block ? spare_reg : cur_reg;
        word_idx = {head.pos, 1'b0};
        ks       = {ks_src[word_idx + 4'd1], ks_src[word_idx]};
        for (int b = 0; b < 8; b++) begin
            mask[8*b +: 8] = (4'(b) < head.count) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        cur_next         = cur_reg;
        spare_next       = spare_reg;
        spare_tag_next   = spare_tag_reg;
        spare_valid_next = spare_valid_reg;
        pf_pending_next  = pf_pending_reg;
        pf_ctr_next      = pf_ctr_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        m_count_next     = m_count_reg;
        m_last_next      = m_last_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next = 1'b1;
            m_data_next  = (head.data ^ ks) & mask;
            m_count_next = head.count;
            m_last_next  = head.last;
        end

        // Block bookkeeping: take a hit, drop a stale block, store a finished one.
        if (pop && head.new_block) begin
            cur_next         = spare_reg;
            spare_valid_next = 1'b0;
            pf_pending_next  = 1'b1;
            pf_ctr_next      = spare_tag_reg + 32'd1;
        end else if (stale) begin
            spare_valid_next = 1'b0;
        end
        if (core_start) begin
            pf_pending_next = 1'b0;
        end
        if (core_done) begin
            spare_next       = core_result;
            spare_tag_next   = core_ctr;
            spare_valid_next = 1'b1;
        end
        if (cfg_change) begin
            spare_valid_next = 1'b0;
            pf_pending_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spare_valid_reg <= 1'b0;
            pf_pending_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            spare_valid_reg <= spare_valid_next;
            pf_pending_reg  <= pf_pending_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        spare_reg     <= spare_next;
        spare_tag_reg <= spare_tag_next;
        pf_ctr_reg    <= pf_ctr_next;
        m_data_reg    <= m_data_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - DATA_W - COUNT_W){1'b0}}, m_count_reg, m_data_reg};
    assign m_tlast  = m_last_reg;

    assign stat.core_busy   = core_busy;
    assign stat.spare_valid = spare_valid_reg;

endmodule

[bench/cc20_xor_checker.sv]
`timescale 1ns / 100ps
// Register index names shared by the bench, and the checker of the ChaCha20 stream XOR block.
// Depends on cc20_pkg for the stream widths; the bench top imports cc20_bench_pkg.

package cc20_bench_pkg;

    // Write-port register map; the last index is not mapped to any register.
    typedef enum logic [2:0] {
        REG_KEY_0        = 3'd0,
        REG_KEY_1        = 3'd1,
        REG_KEY_2        = 3'd2,
        REG_KEY_3        = 3'd3,
        REG_NONCE_LOW    = 3'd4,
        REG_NONCE_HIGH   = 3'd5,
        REG_INIT_COUNTER = 3'd6,
        REG_UNMAPPED     = 3'd7
    } reg_index_e;

endpackage

module cc20_xor_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [cc20_pkg::TDATA_W-1:0] s_tdata,   // data_in [63:0], byte_count [67:64]
    input  logic                         s_tlast,   // last_of_message
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [cc20_pkg::TDATA_W-1:0] m_tdata,   // data_out [63:0], out_count [67:64]
    input  logic                         m_tlast,   // out_last
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_addr,
    input  logic [63:0]                  cfg_wdata,
    output int                           mismatch_count,
    output int                           pending_count
);
    import cc20_pkg::*;
    import cc20_bench_pkg::*;

    localparam logic [31:0] EXPAND_0 = 32'h61707865;
    localparam logic [31:0] EXPAND_1 = 32'h3320646e;
    localparam logic [31:0] EXPAND_2 = 32'h79622d32;
    localparam logic [31:0] EXPAND_3 = 32'h6b206574;
    localparam int ROUND_PAIRS = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               last;
    } cipher_out_t;

    // Configuration copy.
    logic [31:0] key_word [8];
    logic [31:0] nonce_word [3];
    logic [31:0] start_counter;

    // Cipher state: current keystream block, counter of the next block, slot within it.
    logic [31:0] keystream [16];
    logic [31:0] mix_word [16];
    logic [31:0] block_ctr;
    logic [2:0]  slot;
    logic        in_message;

    cipher_out_t ciphertext_q [$];

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One quarter round applied in place to four words of the working block.
    task automatic quarter(input int a, input int b, input int c, input int d);
        mix_word[a] = mix_word[a] + mix_word[b];
        mix_word[d] = rol32(mix_word[d] ^ mix_word[a], 16);
        mix_word[c] = mix_word[c] + mix_word[d];
        mix_word[b] = rol32(mix_word[b] ^ mix_word[c], 12);
        mix_word[a] = mix_word[a] + mix_word[b];
        mix_word[d] = rol32(mix_word[d] ^ mix_word[a], 8);
        mix_word[c] = mix_word[c] + mix_word[d];
        mix_word[b] = rol32(mix_word[b] ^ mix_word[c], 7);
    endtask

    // Generates the 64-byte keystream block for the given block counter.
    task automatic build_keystream(input logic [31:0] ctr);
        logic [31:0] seed [16];
        int i;
        seed[0] = EXPAND_0;
        seed[1] = EXPAND_1;
        seed[2] = EXPAND_2;
        seed[3] = EXPAND_3;
        for (i = 0; i < 8; i++) seed[4 + i] = key_word[i];
        seed[12] = ctr;
        for (i = 0; i < 3; i++) seed[13 + i] = nonce_word[i];
        for (i = 0; i < 16; i++) mix_word[i] = seed[i];
        for (i = 0; i < ROUND_PAIRS; i++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++) keystream[i] = mix_word[i] + seed[i];
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [63:0] v);
        case (idx)
            REG_KEY_0: begin
                key_word[0] = v[31:0];
                key_word[1] = v[63:32];
            end
            REG_KEY_1: begin
                key_word[2] = v[31:0];
                key_word[3] = v[63:32];
            end
            REG_KEY_2: begin
                key_word[4] = v[31:0];
                key_word[5] = v[63:32];
            end
            REG_KEY_3: begin
                key_word[6] = v[31:0];
                key_word[7] = v[63:32];
            end
            REG_NONCE_LOW: begin
                nonce_word[0] = v[31:0];
                nonce_word[1] = v[63:32];
            end
            REG_NONCE_HIGH: nonce_word[2] = v[31:0];
            REG_INIT_COUNTER: start_counter = v[31:0];
            default: ;
        endcase
    endtask

    // Works out the ciphertext of one accepted input transfer.
    task automatic encrypt_item(input logic [DATA_W-1:0] d, input logic [COUNT_W-1:0] c,
                                input logic l);
        cipher_out_t res;
        logic [DATA_W-1:0] ks;
        logic [DATA_W-1:0] mask;
        logic [COUNT_W-1:0] n;
        n = (c > MAX_COUNT) ? MAX_COUNT : c;
        if (!in_message) begin
            block_ctr = start_counter;
            slot = '0;
            in_message = 1'b1;
        end
        if (slot == 3'd0) begin
            build_keystream(block_ctr);
            block_ctr = block_ctr + 32'd1;
        end
        ks = {keystream[2 * slot + 1], keystream[2 * slot]};
        mask = (n == MAX_COUNT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        res.data = (d ^ ks) & mask;
        res.count = n;
        res.last = l;
        ciphertext_q.push_back(res);
        slot = slot + 3'd1;
        // The end of a message rewinds the counter for the next one.
        if (l) begin
            in_message = 1'b0;
            slot = '0;
            block_ctr = start_counter;
        end
    endtask

    task automatic check_result(input logic [DATA_W-1:0] d, input logic [COUNT_W-1:0] c,
                                input logic l);
        cipher_out_t want;
        if (ciphertext_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: output transfer with nothing expected: data %h count %0d last %0b",
                         $time, d, c, l);
        end else begin
            want = ciphertext_q.pop_front();
            if (want.data !== d || want.count !== c || want.last !== l) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: mismatch: expected data %h count %0d last %0b, got data %h count %0d last %0b",
                             $time, want.data, want.count, want.last, d, c, l);
            end
        end
    endtask

    // Register writes, then input transfers, then output transfers of the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) key_word[i] = '0;
            for (int i = 0; i < 3; i++) nonce_word[i] = '0;
            for (int i = 0; i < 16; i++) keystream[i] = '0;
            start_counter = '0;
            block_ctr = '0;
            slot = '0;
            in_message = 1'b0;
            mismatch_count = 0;
            ciphertext_q.delete();
        end else begin
            if (cfg_wr_en)
                apply_write(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                encrypt_item(s_tdata[DATA_W-1:0], s_tdata[DATA_W +: COUNT_W], s_tlast);
            if (m_tvalid && m_tready)
                check_result(m_tdata[DATA_W-1:0], m_tdata[DATA_W +: COUNT_W], m_tlast);
        end
        pending_count <= ciphertext_q.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the ChaCha20 stream XOR bench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on cc20_pkg, cc20_bench_pkg, cc20_xor_checker and the chacha20_stream_xor RTL.

module testbench;
    import cc20_pkg::*;
    import cc20_bench_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_ITEMS = 500;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [63:0]        cfg_wdata = '0;

    int          mismatch_count;
    int          pending_count;
    int          items_sent = 0;
    int          random_goal;
    int          phase_goal;
    logic        src_steady = 1'b0;
    logic        sink_steady = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned ready_pick;
    int unsigned cycle_count = 0;

    chacha20_stream_xor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    cc20_xor_checker watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #10 aclk = ~aclk;

    // Receiver: holds tready high or low for random stretches, mostly short.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (sink_steady || ready_pick < 60) begin
                m_tready <= 1'b1;
                ready_hold <= $urandom_range(0, 8);
            end else if (ready_pick < 92) begin
                m_tready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("chacha20_stream_xor regression: fail");
            $finish;
        end
    end

    function automatic int unsigned source_gap();
        int unsigned r;
        if (src_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one input transfer after a random gap and waits until it is taken.
    task automatic send_item(input logic [DATA_W-1:0] d, input logic [COUNT_W-1:0] c,
                             input logic l);
        int unsigned gap;
        gap = source_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W - DATA_W - COUNT_W){1'b0}}, c, d};
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Stops the source and waits until every expected transfer has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [63:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // New key, nonce and start counter; the counter often sits near the wrap point or at zero.
    task automatic random_setup();
        logic [31:0] ctr;
        write_reg(REG_KEY_0, {$urandom, $urandom});
        write_reg(REG_KEY_1, {$urandom, $urandom});
        write_reg(REG_KEY_2, {$urandom, $urandom});
        write_reg(REG_KEY_3, {$urandom, $urandom});
        write_reg(REG_NONCE_LOW, {$urandom, $urandom});
        write_reg(REG_NONCE_HIGH, {$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: ctr = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: ctr = '0;
            default: ctr = $urandom;
        endcase
        write_reg(REG_INIT_COUNTER, {$urandom, ctr});
    endtask

    // One message of full transfers with a short tail, some odd byte counts mixed in,
    // and optionally a register write in the middle once the block is idle.
    task automatic send_message(input int n, input int rewrite_at);
        logic [COUNT_W-1:0] c;
        int i;
        for (i = 0; i < n; i++) begin
            if (i == rewrite_at) begin
                drain();
                write_reg(reg_index_e'($urandom_range(0, 7)), {$urandom, $urandom});
            end
            if ($urandom_range(0, 99) < 8)
                c = COUNT_W'($urandom_range(0, 15));
            else if (i == n - 1)
                c = COUNT_W'($urandom_range(1, 8));
            else
                c = MAX_COUNT;
            send_item({$urandom, $urandom}, c, i == n - 1);
        end
    endtask

    initial begin
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: a one-transfer message, then a message across a block
        // boundary with all-ones data, a zero count, a short transfer before the end
        // and a count above eight.
        send_item('0, MAX_COUNT, 1'b1);
        send_item('1, MAX_COUNT, 1'b0);
        send_item({$urandom, $urandom}, 4'd0, 1'b0);
        send_item({$urandom, $urandom}, 4'd3, 1'b0);
        send_item({$urandom, $urandom}, 4'd15, 1'b0);
        repeat (4) send_item({$urandom, $urandom}, MAX_COUNT, 1'b0);
        send_item({$urandom, $urandom}, 4'd1, 1'b1);
        drain();

        // All-ones key and nonce with the counter about to wrap.
        write_reg(REG_KEY_0, '1);
        write_reg(REG_KEY_1, '1);
        write_reg(REG_KEY_2, '1);
        write_reg(REG_KEY_3, '1);
        write_reg(REG_NONCE_LOW, '1);
        write_reg(REG_NONCE_HIGH, '1);
        write_reg(REG_INIT_COUNTER, 64'h0000_0000_FFFF_FFFF);
        repeat (5) send_item({$urandom, $urandom}, MAX_COUNT, 1'b0);

        // Mid-message key change plus a write to the unmapped index; the new key
        // only shows from the next block on.
        drain();
        write_reg(REG_KEY_2, {$urandom, $urandom});
        write_reg(REG_UNMAPPED, '1);
        repeat (4) send_item({$urandom, $urandom}, MAX_COUNT, 1'b0);
        send_item('1, MAX_COUNT, 1'b1);
        drain();

        // Random phases, each with its own configuration and idling style.
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            drain();
            random_setup();
            src_steady <= ($urandom_range(0, 3) == 0);
            sink_steady <= ($urandom_range(0, 3) == 0);
            phase_goal = items_sent + $urandom_range(60, 100);
            while (items_sent < phase_goal && items_sent < random_goal) begin
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(30, 40);
                else
                    n = $urandom_range(1, 20);
                if (n > 2 && $urandom_range(0, 99) < 15)
                    send_message(n, $urandom_range(1, n - 1));
                else
                    send_message(n, -1);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("chacha20_stream_xor regression: pass");
        else
            $display("chacha20_stream_xor regression: fail");
        $finish;
    end

endmodule
